@@ src/ksm_pkg.sv @@
package ksm_pkg;

    // Window and class geometry
    localparam int WIN_LEN   = 40;
    localparam int NUM_CLS   = 12;
    localparam int CODE_W    = 4;
    localparam int POS_W     = $clog2(WIN_LEN);
    localparam int CNT_W     = $clog2(WIN_LEN + 1);
    localparam int CLS_IDX_W = $clog2(NUM_CLS);
    localparam int THR_W     = 6;
    localparam int HOLD_W    = 8;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    localparam logic [CODE_W-1:0] SIL_CODE = CODE_W'(10);
    localparam logic [CODE_W-1:0] MAX_CODE = CODE_W'(NUM_CLS - 1);

    // Register reset values
    localparam logic [THR_W-1:0]  THR_RST  = THR_W'(20);
    localparam logic [HOLD_W-1:0] HOLD_RST = HOLD_W'(40);

    typedef logic [CODE_W-1:0] t_code;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [POS_W-1:0]  t_pos;

    // Register index, taken from paddr[2]
    typedef enum logic {
        REG_THR  = 1'b0,
        REG_HOLD = 1'b1
    } t_reg_idx;

    // Sequencer states, one-hot
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_UPD  = 5'b00010,
        S_ARG  = 5'b00100,
        S_SCAN = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

endpackage

@@ src/ksm_in_if.sv @@
interface ksm_in_if;
    import ksm_pkg::*;

    logic        valid;
    logic        ready;
    logic [CODE_W-1:0] class_code;

    modport source (output valid, output class_code, input ready);
    modport sink   (input valid, input class_code, output ready);
endinterface

@@ src/ksm_out_if.sv @@
interface ksm_out_if;
    import ksm_pkg::*;

    logic              valid;
    logic              ready;
    logic              detect_pulse;
    logic [CODE_W-1:0] detected_class;
    logic [CODE_W-1:0] majority_class;
    logic [CNT_W-1:0]  majority_count;
    logic              in_holdoff;

    modport source (
        output valid, output detect_pulse, output detected_class,
        output majority_class, output majority_count, output in_holdoff,
        input ready
    );
    modport sink (
        input valid, input detect_pulse, input detected_class,
        input majority_class, input majority_count, input in_holdoff,
        output ready
    );
endinterface

@@ src/keyword_result_smoother.sv @@
// keyword_result_smoother
//
// Smooths a stream of keyword classifier codes. i_in carries one class code
// per transfer; o_out carries one result per input: detection pulse and class,
// window majority class and count, and the holdoff flag. Both channels use
// valid/ready. Over APB the user must write run threshold (address 0) and
// holdoff length (address 4) only while idle; the block does not enforce it.
//
// Each item goes from input transfer to result through the update of the
// window and histogram, the argmax over the histogram, and the window scan
// through the single read port of the window memory (cut short when a
// detection ends the scan), then the load of the output register. i_in.ready
// is high only in idle, so the block takes no new item until the previous
// one has finished its scan and loaded its result into the output register.
// A finished result sits in the output register; the next input is
// taken while it waits, and only the end of the following item stalls
// until the receiver takes it.
// Reset returns the window to all silence (per-entry valid bits), the
// histogram to silence only, holdoff off and the registers to 20 and 40.
module keyword_result_smoother (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    ksm_in_if.sink                          i_in,
    ksm_out_if.source                       o_out,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ksm_pkg::APB_AW-1:0]      paddr,
    input  logic [ksm_pkg::APB_DW-1:0]      pwdata,
    output logic [ksm_pkg::APB_DW-1:0]      prdata,
    output logic                            pready
);
    import ksm_pkg::*;

    // Configuration and control state
    logic [THR_W-1:0]  r_thr;
    logic [HOLD_W-1:0] r_hold_len;
    t_state            r_state;
    t_pos              r_wr_pos;
    t_pos              r_rd_ptr;
    t_code             r_prev;
    t_code             r_code;
    logic              r_was_det;
    logic              r_hold_mode;
    logic [HOLD_W-1:0] r_hold_cnt;

    // Window memory with per-entry valid bits
    t_code             r_win [WIN_LEN];
    logic [WIN_LEN-1:0] r_wvld;
    t_code             r_rd_data;
    logic              r_rd_vbit;
    t_pos              rd_addr;
    t_code             rd_word;

    // Histogram lanes and argmax
    t_cnt                 r_hist [NUM_CLS];
    logic [CLS_IDX_W-1:0] r_idx;
    t_code                r_best_cls;
    t_cnt                 r_best_cnt;

    // Scan
    logic  r_rd_pend;
    t_pos  r_scan_cnt;
    t_code r_cur;
    t_cnt  r_run;
    logic  r_fire;
    logic  scan_first;
    logic  scan_match;
    t_cnt  n_run;
    logic  n_fire;

    // Output register
    logic  r_out_vld;
    logic  r_out_pulse;
    t_code r_out_dcls;
    t_code r_out_mcls;
    t_cnt  r_out_mcnt;
    logic  r_out_hold;

    logic  in_xfer;
    logic  out_free;
    t_code in_clamped;
    t_code old_word;
    t_code n_entry;
    logic [HOLD_W-1:0] n_hold_cnt;
    logic  n_hold_mode;
    logic  cfg_wr;
    t_reg_idx cfg_idx;

    function automatic t_pos next_pos(input t_pos p);
        t_pos q;
        if (p == POS_W'(WIN_LEN - 1)) begin
            q = '0;
        end else begin
            q = p + 1'b1;
        end
        return q;
    endfunction

    assign in_xfer    = i_in.valid && i_in.ready;
    assign out_free   = !r_out_vld || o_out.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign in_clamped = (i_in.class_code > MAX_CODE) ? MAX_CODE : i_in.class_code;

    // APB register file
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = t_reg_idx'(paddr[2]);

    always_comb begin
        unique case (cfg_idx)
            REG_THR:  prdata = APB_DW'(r_thr);
            REG_HOLD: prdata = APB_DW'(r_hold_len);
            default:  prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr      <= THR_RST;
            r_hold_len <= HOLD_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_THR:  r_thr      <= pwdata[THR_W-1:0];
                REG_HOLD: r_hold_len <= pwdata[HOLD_W-1:0];
                default:  ;
            endcase
        end
    end

    // Window memory: one read port, one write port
    assign rd_addr  = (r_state == S_IDLE) ? r_wr_pos : r_rd_ptr;
    assign rd_word  = r_rd_vbit ? r_rd_data : SIL_CODE;
    assign old_word = rd_word;
    assign n_entry  = (r_was_det && (r_code == r_prev)) ? r_code : SIL_CODE;

    always_ff @(posedge i_clk) begin
        if (r_state == S_UPD) begin
            r_win[r_wr_pos] <= n_entry;
        end
        r_rd_data <= r_win[rd_addr];
        r_rd_vbit <= r_wvld[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wvld <= '0;
        end else if (r_state == S_UPD) begin
            r_wvld[r_wr_pos] <= 1'b1;
        end
    end

    // Histogram lanes: drop the evicted code, count the entering one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CLS; c++) begin
                r_hist[c] <= (CODE_W'(c) == SIL_CODE) ? CNT_W'(WIN_LEN) : '0;
            end
        end else if (r_state == S_UPD) begin
            for (int c = 0; c < NUM_CLS; c++) begin
                if (n_entry == CODE_W'(c) && old_word != CODE_W'(c)) begin
                    r_hist[c] <= r_hist[c] + 1'b1;
                end else if (old_word == CODE_W'(c) && n_entry != CODE_W'(c)) begin
                    r_hist[c] <= r_hist[c] - 1'b1;
                end
            end
        end
    end

    // Scan step: run counter restarts at zero on a class change
    assign scan_first = (r_scan_cnt == '0);
    assign scan_match = scan_first || (rd_word == r_cur);
    assign n_run      = scan_match ? (r_run + 1'b1) : '0;
    assign n_fire     = (n_run == CNT_W'(r_thr)) && (rd_word != SIL_CODE) && r_was_det;

    // Holdoff update for the finished item
    always_comb begin
        n_hold_cnt  = '0;
        n_hold_mode = r_hold_mode;
        if (r_was_det) begin
            if (r_fire) begin
                n_hold_mode = 1'b1;
            end
        end else begin
            n_hold_cnt = r_hold_cnt + 1'b1;
            if (n_hold_cnt == r_hold_len) begin
                n_hold_mode = 1'b0;
            end
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wr_pos    <= '0;
            r_prev      <= SIL_CODE;
            r_hold_mode <= 1'b0;
            r_hold_cnt  <= '0;
            r_rd_pend   <= 1'b0;
            r_fire      <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_code    <= in_clamped;
                        r_was_det <= !r_hold_mode;
                        r_state   <= S_UPD;
                    end
                end
                S_UPD: begin
                    r_prev     <= r_code;
                    r_wr_pos   <= next_pos(r_wr_pos);
                    r_rd_ptr   <= next_pos(r_wr_pos);
                    r_idx      <= '0;
                    r_best_cls <= '0;
                    r_best_cnt <= '0;
                    r_state    <= S_ARG;
                end
                S_ARG: begin
                    if (r_hist[r_idx] > r_best_cnt) begin
                        r_best_cls <= CODE_W'(r_idx);
                        r_best_cnt <= r_hist[r_idx];
                    end
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == CLS_IDX_W'(NUM_CLS - 1)) begin
                        r_scan_cnt <= '0;
                        r_run      <= '0;
                        r_rd_pend  <= 1'b0;
                        r_fire     <= 1'b0;
                        r_state    <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_rd_ptr  <= next_pos(r_rd_ptr);
                    r_rd_pend <= 1'b1;
                    if (r_rd_pend) begin
                        r_cur      <= rd_word;
                        r_run      <= n_run;
                        r_scan_cnt <= r_scan_cnt + 1'b1;
                        if (n_fire) begin
                            r_fire  <= 1'b1;
                            r_state <= S_DONE;
                        end else if (r_scan_cnt == POS_W'(WIN_LEN - 1)) begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_hold_mode <= n_hold_mode;
                        r_hold_cnt  <= n_hold_cnt;
                        r_rd_pend   <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (r_state == S_DONE && out_free) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            r_out_pulse <= r_fire;
            r_out_dcls  <= r_fire ? r_cur : '0;
            r_out_mcls  <= r_best_cls;
            r_out_mcnt  <= r_best_cnt;
            r_out_hold  <= n_hold_mode;
        end
    end

    assign o_out.valid          = r_out_vld;
    assign o_out.detect_pulse   = r_out_pulse;
    assign o_out.detected_class = r_out_dcls;
    assign o_out.majority_class = r_out_mcls;
    assign o_out.majority_count = r_out_mcnt;
    assign o_out.in_holdoff     = r_out_hold;

`ifndef NO_ASSERTIONS
    a_det_holdoff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.detect_pulse) |-> o_out.in_holdoff)
        else $error("detection without holdoff");

    a_det_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.detect_pulse) |-> (o_out.detected_class != SIL_CODE))
        else $error("detection on silence");

    a_maj_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.majority_count != '0))
        else $error("majority count zero");

    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (r_state == S_UPD))
        else $error("accepted item did not start update");
`endif

endmodule

@@ bench/tb_top.sv @@
module tb_top;
    import ksm_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_WAIT  = 64;
    localparam int PRINT_CAP   = 60;

    // One result as the block should produce it
    typedef struct packed {
        logic  detect;
        t_code det_class;
        t_code maj_class;
        t_cnt  maj_count;
        logic  holdoff;
    } t_smooth_out;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    ksm_in_if  in_if ();
    ksm_out_if out_if ();

    keyword_result_smoother u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    int unsigned src_idle_pct = 0;
    int unsigned snk_stall_pct = 0;
    int unsigned err_cnt = 0;
    int unsigned cycle_cnt = 0;

    // Predictor state: window, histogram, last clamped code, holdoff tracking
    t_code       win_mem [WIN_LEN];
    t_cnt        class_hist [NUM_CLS];
    int          wr_pos;
    t_code       prev_code;
    logic        hold_mode;
    logic [7:0]  hold_cnt;
    logic [THR_W-1:0]  thr_cfg;
    logic [HOLD_W-1:0] hold_cfg;

    t_smooth_out smooth_results_q [$];

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        if (err_cnt < PRINT_CAP)
            $display("mismatch at cycle %0d: %s got %0d want %0d", cycle_cnt, what, got, want);
        err_cnt++;
    endtask

    function automatic void smoother_reset();
        for (int i = 0; i < WIN_LEN; i++)
            win_mem[i] = SIL_CODE;
        for (int i = 0; i < NUM_CLS; i++)
            class_hist[i] = '0;
        class_hist[SIL_CODE] = t_cnt'(WIN_LEN);
        wr_pos    = 0;
        prev_code = SIL_CODE;
        hold_mode = 1'b0;
        hold_cnt  = '0;
        thr_cfg   = THR_RST;
        hold_cfg  = HOLD_RST;
    endfunction

    // Advance the predictor by one class code and return the expected result
    function automatic t_smooth_out smooth_step(input t_code raw);
        t_code       code;
        t_code       entry;
        t_code       cur;
        logic        was_det;
        logic        fire;
        int          p;
        int          run;
        int          best_cls;
        int          best_cnt;
        t_smooth_out res;

        code    = (raw > MAX_CODE) ? MAX_CODE : raw;
        was_det = !hold_mode;
        fire    = 1'b0;

        // replace the oldest entry; only repeated codes outside holdoff get in
        p = wr_pos;
        class_hist[win_mem[p]] = class_hist[win_mem[p]] - 1'b1;
        entry = (code == prev_code && was_det) ? code : SIL_CODE;
        win_mem[p] = entry;
        class_hist[entry] = class_hist[entry] + 1'b1;
        p = (p == WIN_LEN - 1) ? 0 : p + 1;
        wr_pos = p;

        // majority, lowest index wins ties
        best_cls = 0;
        best_cnt = 0;
        for (int i = 0; i < NUM_CLS; i++) begin
            if (int'(class_hist[i]) > best_cnt) begin
                best_cls = i;
                best_cnt = int'(class_hist[i]);
            end
        end

        // oldest-to-newest run scan; counter drops to zero on a class change
        cur = win_mem[p];
        run = 0;
        for (int i = 0; i < WIN_LEN; i++) begin
            if (win_mem[p] == cur) begin
                run++;
            end else begin
                cur = win_mem[p];
                run = 0;
            end
            if (run == int'(thr_cfg) && cur != SIL_CODE && was_det) begin
                fire = 1'b1;
                break;
            end
            p = (p == WIN_LEN - 1) ? 0 : p + 1;
        end

        // holdoff bookkeeping
        if (was_det) begin
            hold_cnt = '0;
            if (fire)
                hold_mode = 1'b1;
        end else begin
            hold_cnt = hold_cnt + 8'd1;
            if (hold_cnt == hold_cfg)
                hold_mode = 1'b0;
        end
        prev_code = code;

        res.detect    = fire;
        res.det_class = fire ? cur : t_code'(0);
        res.maj_class = t_code'(best_cls);
        res.maj_count = t_cnt'(best_cnt);
        res.holdoff   = hold_mode;
        return res;
    endfunction

    // Input monitor: predict on every accepted code
    always @(posedge i_clk) begin
        if (i_rst_n && in_if.valid && in_if.ready)
            smooth_results_q.push_back(smooth_step(in_if.class_code));
    end

    // Result checker
    t_smooth_out want_res;
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (smooth_results_q.size() == 0) begin
                report_mismatch("unexpected result, majority_class", out_if.majority_class, 0);
            end else begin
                want_res = smooth_results_q.pop_front();
                if (out_if.detect_pulse !== want_res.detect)
                    report_mismatch("detect_pulse", out_if.detect_pulse, want_res.detect);
                if (out_if.detected_class !== want_res.det_class)
                    report_mismatch("detected_class", out_if.detected_class,
                                    want_res.det_class);
                if (out_if.majority_class !== want_res.maj_class)
                    report_mismatch("majority_class", out_if.majority_class,
                                    want_res.maj_class);
                if (out_if.majority_count !== want_res.maj_count)
                    report_mismatch("majority_count", out_if.majority_count,
                                    want_res.maj_count);
                if (out_if.in_holdoff !== want_res.holdoff)
                    report_mismatch("in_holdoff", out_if.in_holdoff, want_res.holdoff);
            end
        end
    end

    // Receiver back-pressure
    always @(posedge i_clk) begin
        out_if.ready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Send one class code; valid stays up between back-to-back transfers
    task automatic send_code(input t_code code);
        while ($urandom_range(99) < src_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid      <= 1'b1;
        in_if.class_code <= code;
        do @(posedge i_clk); while (!in_if.ready);
    endtask

    // Stop sending and wait until every expected result has come back;
    // the wait starts only once the last transfer is in the queue
    task automatic wait_drained();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (smooth_results_q.size() != 0)
            @(posedge i_clk);
    endtask

    // Register write followed by a read-back in the next transfer
    task automatic reg_write(input t_reg_idx idx, input int unsigned value);
        logic [APB_DW-1:0] data;
        int                w;

        w    = (idx == REG_THR) ? THR_W : HOLD_W;
        data = APB_DW'(value) & ((APB_DW'(1) << w) - 1);
        // junk above the field must be dropped
        data = data | (APB_DW'($urandom) << w);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx == REG_THR)
            thr_cfg = data[THR_W-1:0];
        else
            hold_cfg = data[HOLD_W-1:0];

        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx == REG_THR) begin
            if (prdata[THR_W-1:0] !== thr_cfg)
                report_mismatch("run_threshold read-back", prdata[THR_W-1:0], thr_cfg);
        end else begin
            if (prdata[HOLD_W-1:0] !== hold_cfg)
                report_mismatch("holdoff_length read-back", prdata[HOLD_W-1:0], hold_cfg);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_config(input int unsigned thr, input int unsigned hold);
        wait_drained();
        reg_write(REG_THR, thr);
        reg_write(REG_HOLD, hold);
    endtask

    // Out-of-range codes, short runs, holdoff entry and exit
    task automatic test_clamp_and_runs();
        t_code codes [$];

        src_idle_pct  = 0;
        snk_stall_pct = 0;
        set_config(2, 3);
        codes = '{4'd15, 4'd12, 4'd13, 4'd14, 4'd3, 4'd3, 4'd3, 4'd3, 4'd0, 4'd0,
                  4'd0, 4'd9, 4'd9, 4'd9, 4'd9, 4'd10, 4'd10, 4'd11, 4'd11, 4'd7};
        foreach (codes[i])
            send_code(codes[i]);
    endtask

    // Threshold zero fires right after a change to a keyword class
    task automatic test_zero_threshold();
        t_code codes [$];

        set_config(0, 1);
        codes = '{4'd6, 4'd6, 4'd10, 4'd10, 4'd2, 4'd2};
        foreach (codes[i])
            send_code(codes[i]);
    endtask

    // Random traffic: mostly bursts of one code around the threshold, some noise
    task automatic run_segment(input int unsigned thr, input int unsigned hold,
                               input int n_items);
        int    sent;
        int    len;
        int    top;
        t_code code;

        set_config(thr, hold);
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(99) < 75) begin
                code = t_code'($urandom_range(15));
                if ($urandom_range(3) != 0)
                    code = t_code'($urandom_range(9));
                top = ((thr < 48) ? thr : 48) + 6;
                len = $urandom_range(top, 2);
                for (int i = 0; i < len; i++)
                    send_code(code);
            end else begin
                len = $urandom_range(4, 1);
                for (int i = 0; i < len; i++)
                    send_code(t_code'($urandom_range(15)));
            end
            sent += len;
        end
    endtask

    task automatic test_no_idle();
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        run_segment(20, 40, 225);
        run_segment(1, 1, 225);
    endtask

    task automatic test_sender_idle();
        src_idle_pct  = 48;
        snk_stall_pct = 0;
        run_segment(40, 1, 225);
        run_segment(1, 255, 225);
    endtask

    task automatic test_receiver_stall();
        src_idle_pct  = 0;
        snk_stall_pct = 48;
        run_segment(0, 7, 225);
        run_segment(63, 100, 225);
    endtask

    task automatic test_both_idle();
        src_idle_pct  = 13;
        snk_stall_pct = 13;
        run_segment(5, 0, 225);
        run_segment(33, 17, 225);
    endtask

    // Test sequence
    initial begin
        i_rst_n          <= 1'b0;
        in_if.valid      <= 1'b0;
        in_if.class_code <= SIL_CODE;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        smoother_reset();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_clamp_and_runs();
        test_zero_threshold();
        test_no_idle();
        test_sender_idle();
        test_receiver_stall();
        test_both_idle();

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (err_cnt == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
